>>> hw/rtl/grid_velocity_interpolator_macros.svh
// Assertion helpers for the velocity interpolator.
// GVI_ASSERT is gated off while reset is low; GVI_ASSERT_NR checks through reset too.
`ifndef GRID_VELOCITY_INTERPOLATOR_MACROS_SVH
`define GRID_VELOCITY_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS
`define GVI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define GVI_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define GVI_ASSERT(lbl, prop, msg)
`define GVI_ASSERT_NR(lbl, prop, msg)
`endif

`endif

>>> hw/rtl/gvi_pkg.sv
package gvi_pkg;

  // Default geometry and precision
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int FRAC_BITS_DEF   = 8;

  // Fixed field widths
  localparam int POS_W      = 14;
  localparam int CELL_W     = 6;
  localparam int VEL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SHIFT_W    = 4;

  // Register reset values
  localparam logic [CFG_DATA_W-1:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [CFG_DATA_W-1:0] GRID_HEIGHT_RST = 7'd64;
  localparam logic [SHIFT_W-1:0]    CELL_SHIFT_RST  = 4'd8;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_CELL_SHIFT  = 2'd2
  } cfg_idx_e;

  // Which of the three neighbor reads is issued
  typedef enum logic [1:0] {
    STEP_NEAR = 2'd0,
    STEP_MID  = 2'd1,
    STEP_FAR  = 2'd2
  } rd_step_e;

  // Controller to datapath
  typedef struct packed {
    logic     capture;   // request accepted: latch fields; store write on an in-range write request
    logic     rd_en;     // issue one read on both stores
    rd_step_e rd_step;
    logic     grab0;     // latch first read data
    logic     grab1;     // latch second read data
    logic     mix;       // form doubled centered values
    logic     load_out;  // load result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic outside;
  } status_t;

endpackage

>>> hw/rtl/gvi_ram.sv
module gvi_ram import gvi_pkg::*; #(
  parameter int WIDTH = VEL_W,
  parameter int DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/gvi_ctrl.sv
module gvi_ctrl import gvi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    kind_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

`include "grid_velocity_interpolator_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_LAST,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: three paired reads, combine, multiply into result register; writes and border queries skip the reads
  always_comb begin
    cmd_o         = '0;
    cmd_o.rd_step = STEP_NEAR;
    state_d       = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = kind_i ? S_RD0 : S_FINISH;
        end
      end
      S_RD0: begin
        if (status_i.outside) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_step = STEP_NEAR;
          state_d       = S_RD1;
        end
      end
      S_RD1: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_step = STEP_MID;
        cmd_o.grab0   = 1'b1;
        state_d       = S_RD2;
      end
      S_RD2: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_step = STEP_FAR;
        cmd_o.grab1   = 1'b1;
        state_d       = S_LAST;
      end
      S_LAST: begin
        cmd_o.mix = 1'b1;
        state_d   = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `GVI_ASSERT(a_rd0_after_query, (state_q == S_RD0) |-> $past(in_valid_i && in_ready_o && kind_i), "read sequence started without a query")
  `GVI_ASSERT(a_write_to_finish, (in_valid_i && in_ready_o && !kind_i) |=> (state_q == S_FINISH), "write request did not go straight to finish")
  `GVI_ASSERT_NR(a_valid_from_finish, $rose(out_valid_q) |-> $past(state_q == S_FINISH), "result valid rose outside finish")

endmodule

>>> hw/rtl/gvi_datapath.sv
module gvi_datapath import gvi_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    kind_i,
  input  logic [CELL_W-1:0]       cell_x_i,
  input  logic [CELL_W-1:0]       cell_y_i,
  input  logic signed [VEL_W-1:0] u_in_i,
  input  logic signed [VEL_W-1:0] v_in_i,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  output logic signed [VEL_W-1:0] u_out_o,
  output logic signed [VEL_W-1:0] v_out_o,
  output logic                    outside_o
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int DIM_W  = $clog2((MAX_COLUMNS > MAX_ROWS ? MAX_COLUMNS : MAX_ROWS) + 1);
  localparam int C_W    = VEL_W + 1;          // doubled centered value
  localparam int D_W    = C_W + 1;            // difference of two of them
  localparam int P_W    = D_W + FRAC_BITS + 1;
  localparam int T_W    = P_W + 2;

  // Configuration registers
  logic [CFG_DATA_W-1:0] grid_width_q, grid_height_q;
  logic [SHIFT_W-1:0]    cell_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_WIDTH_RST;
      grid_height_q <= GRID_HEIGHT_RST;
      cell_shift_q  <= CELL_SHIFT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        CFG_CELL_SHIFT:  cell_shift_q  <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Cell position, weights and border test from the request fields
  logic [DIM_W-1:0]             w_eff, h_eff;
  logic [POS_W-1:0]             x0_full, y0_full, fmask;
  logic [POS_W+FRAC_BITS-1:0]   fx_ext, fy_ext;
  logic [FRAC_BITS-1:0]         ax_d, ay_d;
  logic                         outside_d, last_col_d, last_row_d;

  always_comb begin
    w_eff = (int'(grid_width_q) > MAX_COLUMNS) ? DIM_W'(MAX_COLUMNS) : DIM_W'(grid_width_q);
    h_eff = (int'(grid_height_q) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : DIM_W'(grid_height_q);
    x0_full = pos_x_i >> cell_shift_q;
    y0_full = pos_y_i >> cell_shift_q;
    fmask   = ~({POS_W{1'b1}} << cell_shift_q);
    fx_ext  = {pos_x_i & fmask, {FRAC_BITS{1'b0}}};
    fy_ext  = {pos_y_i & fmask, {FRAC_BITS{1'b0}}};
    ax_d    = FRAC_BITS'(fx_ext >> cell_shift_q);
    ay_d    = FRAC_BITS'(fy_ext >> cell_shift_q);
    // inside needs 1 <= x0 <= w-2 and 1 <= y0 <= h-2
    outside_d = (x0_full == '0) || (int'(x0_full) + 2 > int'(w_eff)) ||
                (y0_full == '0) || (int'(y0_full) + 2 > int'(h_eff));
    last_col_d = (int'(x0_full) + 2 == int'(w_eff));
    last_row_d = (int'(y0_full) + 2 == int'(h_eff));
  end

  // Per-request registers
  logic                 query_q, outside_q, last_col_q, last_row_q;
  logic [COL_W-1:0]     x0_q;
  logic [ROW_W-1:0]     y0_q;
  logic [FRAC_BITS-1:0] ax_q, ay_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      query_q    <= kind_i;
      outside_q  <= outside_d;
      last_col_q <= last_col_d;
      last_row_q <= last_row_d;
      x0_q       <= COL_W'(x0_full);
      y0_q       <= ROW_W'(y0_full);
      ax_q       <= ax_d;
      ay_q       <= ay_d;
    end
  end

  assign status_o.outside = outside_q;

  // Store addressing: row * MAX_COLUMNS + column
  logic              we;
  logic [ADDR_W-1:0] waddr, u_raddr, v_raddr;
  logic [1:0]        u_off, v_off;

  assign we    = cmd_i.capture && !kind_i &&
                 (int'(cell_x_i) < MAX_COLUMNS) && (int'(cell_y_i) < MAX_ROWS);
  assign waddr = ADDR_W'(int'(cell_y_i) * MAX_COLUMNS + int'(cell_x_i));

  // u walks right along the row, v walks up the column; the far read
  // repeats the middle one at the last column or row in use
  always_comb begin
    case (cmd_i.rd_step)
      STEP_NEAR: begin
        u_off = 2'd0;
        v_off = 2'd0;
      end
      STEP_MID: begin
        u_off = 2'd1;
        v_off = 2'd1;
      end
      STEP_FAR: begin
        u_off = last_col_q ? 2'd1 : 2'd2;
        v_off = last_row_q ? 2'd1 : 2'd2;
      end
      default: begin
        u_off = 2'd0;
        v_off = 2'd0;
      end
    endcase
    u_raddr = ADDR_W'(int'(y0_q) * MAX_COLUMNS + int'(x0_q) + int'(u_off));
    v_raddr = ADDR_W'((int'(y0_q) + int'(v_off)) * MAX_COLUMNS + int'(x0_q));
  end

  logic [VEL_W-1:0] u_rdata, v_rdata;

  gvi_ram #(
    .WIDTH (VEL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (u_in_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  gvi_ram #(
    .WIDTH (VEL_W),
    .DEPTH (DEPTH)
  ) v_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (v_in_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // Collect read data, form doubled centered values
  logic signed [VEL_W-1:0] u_a_q, u_b_q, v_a_q, v_b_q;
  logic signed [C_W-1:0]   uc0_q, uc1_q, vc0_q, vc1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.grab0) begin
      u_a_q <= u_rdata;
      v_a_q <= v_rdata;
    end
    if (cmd_i.grab1) begin
      u_b_q <= u_rdata;
      v_b_q <= v_rdata;
    end
    if (cmd_i.mix) begin
      uc0_q <= C_W'(u_a_q) + C_W'(u_b_q);
      vc0_q <= C_W'(v_a_q) + C_W'(v_b_q);
      uc1_q <= last_col_q ? C_W'(u_b_q) : C_W'(u_b_q) + C_W'($signed(u_rdata));
      vc1_q <= last_row_q ? C_W'(v_b_q) : C_W'(v_b_q) + C_W'($signed(v_rdata));
    end
  end

  // c0 + (c1 - c0) * alpha, halved with rounding to nearest, ties toward plus infinity
  function automatic logic signed [VEL_W-1:0] blend(
    input logic signed [C_W-1:0]   c0,
    input logic signed [C_W-1:0]   c1,
    input logic [FRAC_BITS-1:0]    a
  );
    logic signed [D_W-1:0]         diff;
    logic signed [FRAC_BITS:0]     a_s;
    logic signed [P_W-1:0]         prod;
    logic signed [T_W-1:0]         t;
    diff = D_W'(c1) - D_W'(c0);
    a_s  = $signed({1'b0, a});
    prod = diff * a_s;
    t    = (T_W'(c0) <<< FRAC_BITS) + T_W'(prod) + T_W'(1 << FRAC_BITS);
    return t[FRAC_BITS+VEL_W:FRAC_BITS+1];
  endfunction

  // Result register
  logic signed [VEL_W-1:0] u_out_q, v_out_q;
  logic                    outside_out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (!query_q || outside_q) begin
        u_out_q <= '0;
        v_out_q <= '0;
      end else begin
        u_out_q <= blend(uc0_q, uc1_q, ax_q);
        v_out_q <= blend(vc0_q, vc1_q, ay_q);
      end
      outside_out_q <= query_q && outside_q;
    end
  end

  assign u_out_o   = u_out_q;
  assign v_out_o   = v_out_q;
  assign outside_o = outside_out_q;

endmodule

>>> hw/rtl/grid_velocity_interpolator.sv
// Channel   Handshake                 Payload
// cfg       cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// in        in_valid_i/in_ready_o     kind_i, cell_x_i, cell_y_i, u_in_i, v_in_i, pos_x_i, pos_y_i
// out       out_valid_o/out_ready_i   u_out_o, v_out_o, outside_o
//
// A write request goes from capture straight to the result register; an inside query does
// three paired reads of the u and v stores (one read port each), a combine step, a multiply.
// A query on or past the border skips the reads. One request is in flight at a time.
// Reset clears control and loads the registers (width 64, height 64, shift 8);
// the stores have no reset. A stalled result holds the block in its last cycle.
module grid_velocity_interpolator import gvi_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic [CELL_W-1:0]       cell_x_i,
  input  logic [CELL_W-1:0]       cell_y_i,
  input  logic signed [VEL_W-1:0] u_in_i,
  input  logic signed [VEL_W-1:0] v_in_i,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [VEL_W-1:0] u_out_o,
  output logic signed [VEL_W-1:0] v_out_o,
  output logic                    outside_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  gvi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gvi_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .kind_i      (kind_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .u_in_i      (u_in_i),
    .v_in_i      (v_in_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .u_out_o     (u_out_o),
    .v_out_o     (v_out_o),
    .outside_o   (outside_o)
  );

endmodule
